[rtl/core/dkti_pkg.sv]
package dkti_pkg;

  // Item kinds as they arrive on the input channel
  typedef enum logic [2:0] {
    KIND_LOAD    = 3'd0,
    KIND_KEY     = 3'd1,
    KIND_RESTART = 3'd2,
    KIND_ADVANCE = 3'd3,
    KIND_READ    = 3'd4
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ELEM_COUNT  = 2'd0,
    REG_KEY_COUNT   = 2'd1,
    REG_FIRST_START = 2'd2,
    REG_FIRST_END   = 2'd3
  } reg_idx_t;

  localparam logic [16:0] T_ONE = 17'h10000;
  localparam logic [8:0]  ELEM_COUNT_RST = 9'd3;

  // Classified command passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        idx_ok;
    logic [7:0]  idx;
    logic [31:0] start_v;
    logic [31:0] delta_v;
    logic [15:0] kaddr;
    logic [7:0]  kbyte;
    logic [31:0] frame;
  } cmd_t;

  // Configuration seen by the back part
  typedef struct packed {
    logic [8:0]  elem_count;
    logic [15:0] key_count;
    logic [31:0] first_start;
    logic [31:0] first_end;
  } cfg_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic [31:0] sat41(input logic signed [40:0] v);
    logic [31:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -41'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Difference byte times 2^(16+e), floor rounding, saturated
  function automatic logic [31:0] scale_diff(input logic signed [7:0] d,
                                             input logic signed [7:0] e);
    logic signed [9:0]  sh;
    logic signed [9:0]  n;
    logic signed [40:0] p;
    logic signed [7:0]  q;
    logic [31:0]        r;
    sh = 10'sd16 + 10'(e);
    n  = -sh;
    p  = 41'(d);
    q  = d;
    if (d == 8'sd0) begin
      r = 32'd0;
    end else if (sh >= 10'sd0) begin
      if (sh > 10'sd32) begin
        r = (d > 8'sd0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end else begin
        r = sat41(p <<< sh[5:0]);
      end
    end else if (n >= 10'sd8) begin
      r = (d < 8'sd0) ? 32'hFFFF_FFFF : 32'd0;
    end else begin
      q = d >>> n[2:0];
      r = 32'(q);
    end
    return r;
  endfunction

endpackage

[rtl/core/dkti_front.sv]
module dkti_front #(
  parameter int MAX_ELEMS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  logic [2:0]     in_kind,
  input  logic [7:0]     in_elem_index,
  input  logic [31:0]    in_start_value,
  input  logic [31:0]    in_delta_value,
  input  logic [15:0]    in_key_addr,
  input  logic [7:0]     in_key_byte,
  input  logic [31:0]    in_frame_number,
  output logic           cmd_valid,
  output dkti_pkg::cmd_t cmd,
  input  logic           cmd_pop
);
  import dkti_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_beat, keep, rd_beat;
  cmd_t       cmd_in;

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign wr_beat   = in_push && !in_full;
  assign rd_beat   = cmd_pop && cmd_valid;

  // Classify: drop unknown kinds, flag indexes past the element store
  always_comb begin
    keep           = (in_kind <= 3'(KIND_READ));
    cmd_in.kind    = kind_t'(in_kind);
    cmd_in.idx_ok  = (32'(in_elem_index) < MAX_ELEMS);
    cmd_in.idx     = in_elem_index;
    cmd_in.start_v = in_start_value;
    cmd_in.delta_v = in_delta_value;
    cmd_in.kaddr   = in_key_addr;
    cmd_in.kbyte   = in_key_byte;
    cmd_in.frame   = in_frame_number;
  end

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_beat && keep) begin
        q_r[wp_r] <= cmd_in;
        wp_r      <= ~wp_r;
      end
      if (rd_beat) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(wr_beat && keep) - 2'(rd_beat);
    end
  end

endmodule

[rtl/core/dkti_back.sv]
module dkti_back #(
  parameter int MAX_ELEMS = 256,
  parameter int KEY_BYTES = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dkti_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  dkti_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [31:0]    out_value,
  output logic [7:0]     out_value_index
);
  import dkti_pkg::*;

  localparam int EW  = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int NW  = ($clog2(MAX_ELEMS + 1) > 9) ? $clog2(MAX_ELEMS + 1) : 9;
  localparam int KA  = $clog2(KEY_BYTES);
  localparam int KRW = (KA + 1 > 16) ? KA + 1 : 16;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_LOAD = 14'b00000000000010,
    S_KWR  = 14'b00000000000100,
    S_ADV  = 14'b00000000001000,
    S_KEYE = 14'b00000000010000,
    S_KEYW = 14'b00000000100000,
    S_EL   = 14'b00000001000000,
    S_ELW  = 14'b00000010000000,
    S_FRM  = 14'b00000100000000,
    S_FRMW = 14'b00001000000000,
    S_DIV  = 14'b00010000000000,
    S_RD   = 14'b00100000000000,
    S_RDM  = 14'b01000000000000,
    S_RDS  = 14'b10000000000000
  } state_t;

  state_t state_r;
  cmd_t   cmd_r;

  logic [KA-1:0]  rp_r;
  logic [15:0]    keys_left_r;
  logic [31:0]    span_s_r, span_e_r;
  logic [16:0]    t_r;
  logic [NW-1:0]  i_r, n_act;
  logic [1:0]     b_r;
  logic [7:0]     e_r;
  logic [31:0]    ef_r;
  logic [32:0]    rem_r, trial;
  logic [31:0]    den_r;
  logic [16:0]    q_r;
  logic [4:0]     dcnt_r;
  logic           ge;
  logic signed [49:0] prod_r;
  logic [KRW-1:0] kaddr_r;
  logic [KA-1:0]  rp_inc;

  // Memories and their registered read data
  logic [7:0]  key_mem [KEY_BYTES];
  logic [31:0] st_mem [MAX_ELEMS];
  logic [31:0] dl_mem [MAX_ELEMS];
  logic [7:0]  kdata_r;
  logic [31:0] st_rd_r, dl_rd_r;
  logic        key_we, key_re, el_we, el_re;
  logic [EW-1:0] el_wa, el_ra;
  logic [31:0] st_wd, dl_wd, rd_val;

  // Result queue
  logic [31:0] oval_r [2];
  logic [7:0]  oidx_r [2];
  logic        owp_r, orp_r;
  logic [1:0]  ocnt_r;
  logic        o_push, o_pop;

  assign n_act   = (32'(cfg.elem_count) > MAX_ELEMS) ? NW'(MAX_ELEMS) : NW'(cfg.elem_count);
  assign rp_inc  = (32'(rp_r) == KEY_BYTES - 1) ? '0 : rp_r + 1'b1;
  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;

  // Memory port controls
  always_comb begin
    key_we = (state_r == S_KWR) && (32'(kaddr_r) < KEY_BYTES);
    key_re = (state_r == S_KEYE) || (state_r == S_EL) || (state_r == S_FRM);
    el_we  = (state_r == S_LOAD) || (state_r == S_ELW);
    el_re  = (state_r == S_EL) || (state_r == S_RD);
    el_wa  = (state_r == S_LOAD) ? EW'(cmd_r.idx) : i_r[EW-1:0];
    el_ra  = (state_r == S_RD) ? EW'(cmd_r.idx) : i_r[EW-1:0];
    st_wd  = (state_r == S_LOAD) ? cmd_r.start_v
           : sat41(41'(signed'(st_rd_r)) + 41'(signed'(dl_rd_r)));
    dl_wd  = (state_r == S_LOAD) ? cmd_r.delta_v : scale_diff(kdata_r, e_r);
    rd_val = cmd_r.idx_ok
           ? sat41(41'(signed'(st_rd_r)) + 41'(signed'(prod_r[49:16]))) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[kaddr_r[KA-1:0]] <= cmd_r.kbyte;
    end
    if (key_re) begin
      kdata_r <= key_mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (el_we) begin
      st_mem[el_wa] <= st_wd;
      dl_mem[el_wa] <= dl_wd;
    end
    if (el_re) begin
      st_rd_r <= st_mem[el_ra];
      dl_rd_r <= dl_mem[el_ra];
    end
  end

  // One restoring divider step
  always_comb begin
    trial = (dcnt_r == 5'd0) ? rem_r : {rem_r[31:0], 1'b0};
    ge    = (trial >= {1'b0, den_r});
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      keys_left_r <= '0;
      span_s_r    <= '0;
      span_e_r    <= '0;
      t_r         <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            kaddr_r <= KRW'(cmd.kaddr);
            case (cmd.kind)
              KIND_LOAD:    state_r <= cmd.idx_ok ? S_LOAD : S_IDLE;
              KIND_KEY:     state_r <= S_KWR;
              KIND_RESTART: begin
                span_s_r    <= cfg.first_start;
                span_e_r    <= cfg.first_end;
                keys_left_r <= cfg.key_count;
                rp_r        <= '0;
                t_r         <= '0;
              end
              KIND_ADVANCE: state_r <= S_ADV;
              KIND_READ:    state_r <= cmd.idx_ok ? S_RD : S_RDS;
              default:      state_r <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state_r <= S_IDLE;
        // Reduce the byte address into the store, then write
        S_KWR: begin
          if (32'(kaddr_r) >= KEY_BYTES) begin
            kaddr_r <= kaddr_r - KRW'(KEY_BYTES);
          end else begin
            state_r <= S_IDLE;
          end
        end
        // Walk keys while past the span end, then fix t
        S_ADV: begin
          if (cmd_r.frame > span_e_r && keys_left_r != 16'd0) begin
            state_r <= S_KEYE;
          end else if (cmd_r.frame > span_e_r || span_e_r <= span_s_r) begin
            t_r     <= T_ONE;
            state_r <= S_IDLE;
          end else if (cmd_r.frame <= span_s_r) begin
            t_r     <= '0;
            state_r <= S_IDLE;
          end else begin
            rem_r   <= {1'b0, cmd_r.frame - span_s_r};
            den_r   <= span_e_r - span_s_r;
            q_r     <= '0;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_KEYE: begin
          rp_r    <= rp_inc;
          state_r <= S_KEYW;
        end
        S_KEYW: begin
          e_r     <= kdata_r;
          i_r     <= '0;
          b_r     <= '0;
          state_r <= (n_act == '0) ? S_FRM : S_EL;
        end
        S_EL: begin
          rp_r    <= rp_inc;
          state_r <= S_ELW;
        end
        S_ELW: begin
          i_r     <= i_r + 1'b1;
          state_r <= (NW'(i_r + 1'b1) == n_act) ? S_FRM : S_EL;
        end
        S_FRM: begin
          rp_r    <= rp_inc;
          state_r <= S_FRMW;
        end
        // Shift in end frame bytes, low byte first
        S_FRMW: begin
          ef_r <= {kdata_r, ef_r[31:8]};
          b_r  <= b_r + 1'b1;
          if (b_r == 2'd3) begin
            span_s_r    <= span_e_r;
            span_e_r    <= {kdata_r, ef_r[31:8]};
            keys_left_r <= keys_left_r - 1'b1;
            state_r     <= S_ADV;
          end else begin
            state_r <= S_FRM;
          end
        end
        S_DIV: begin
          rem_r  <= ge ? trial - {1'b0, den_r} : trial;
          q_r    <= {q_r[15:0], ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 5'd16) begin
            t_r     <= {q_r[15:0], ge};
            state_r <= S_IDLE;
          end
        end
        S_RD:  state_r <= S_RDM;
        S_RDM: begin
          prod_r  <= 50'(signed'(dl_rd_r)) * 50'(signed'({1'b0, t_r}));
          state_r <= S_RDS;
        end
        S_RDS: begin
          if (ocnt_r != 2'd2) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result queue: push on read completion, pop on output beat
  assign o_push          = (state_r == S_RDS) && (ocnt_r != 2'd2);
  assign o_pop           = out_pop && !out_empty;
  assign out_empty       = (ocnt_r == 2'd0);
  assign out_value       = oval_r[orp_r];
  assign out_value_index = oidx_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (o_push) begin
        oval_r[owp_r] <= rd_val;
        oidx_r[owp_r] <= cmd_r.idx;
        owp_r         <= ~owp_r;
      end
      if (o_pop) begin
        orp_r <= ~orp_r;
      end
      ocnt_r <= ocnt_r + 2'(o_push) - 2'(o_pop);
    end
  end

`ifndef SYNTH
  a_t_bound: assert property (@(posedge clk) disable iff (!rst_n) t_r <= T_ONE)
    else $error("fraction beyond one");
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != 32'd0)
    else $error("divide by empty span");
  a_oq_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r == 2'd2 && !o_pop |=> ocnt_r == 2'd2)
    else $error("result queue lost an entry");
  a_cmd_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> state_r != S_IDLE || $past(cmd.kind) == KIND_RESTART
      || $past(cmd.kind) == KIND_LOAD || $past(cmd.kind) == KIND_READ)
    else $error("command dropped by sequencer");
`endif

endmodule

[rtl/core/delta_keyframe_track_interpolator_top.sv]
// Channel  | Handshake              | Payload
// input    | in_push / in_full      | in_kind, in_elem_index, in_start_value, ...
// result   | out_pop / out_empty    | out_value, out_value_index
// config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// A read passes through the back sequencer states S_RD (element memory read), S_RDM (multiply)
// and S_RDS (sum), which holds while the result queue is full. Loads write both element stores in S_LOAD; key
// byte writes fold the address in S_KWR until it lies in the store. An advance walks keys, then runs 17 divider steps.
// Synchronous active-low reset; no clearing pass, stores are undefined until written.
// A two-entry command queue and a two-entry result queue decouple both sides.
module delta_keyframe_track_interpolator_top #(
  parameter int MAX_ELEMS = 256,
  parameter int KEY_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_elem_index,
  input  logic [31:0] in_start_value,
  input  logic [31:0] in_delta_value,
  input  logic [15:0] in_key_addr,
  input  logic [7:0]  in_key_byte,
  input  logic [31:0] in_frame_number,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_value,
  output logic [7:0]  out_value_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dkti_pkg::*;

  cfg_t     cfg_r;
  cmd_t     cmd;
  logic     cmd_valid, cmd_pop, wr_beat;
  reg_idx_t ridx;

  assign pready  = 1'b1;
  assign ridx    = reg_idx_t'(paddr[3:2]);
  assign wr_beat = psel && penable && pwrite && pready;

  // Register write on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.elem_count  <= ELEM_COUNT_RST;
      cfg_r.key_count   <= '0;
      cfg_r.first_start <= '0;
      cfg_r.first_end   <= '0;
    end else if (wr_beat) begin
      case (ridx)
        REG_ELEM_COUNT:  cfg_r.elem_count  <= pwdata[8:0];
        REG_KEY_COUNT:   cfg_r.key_count   <= pwdata[15:0];
        REG_FIRST_START: cfg_r.first_start <= pwdata;
        REG_FIRST_END:   cfg_r.first_end   <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (ridx)
      REG_ELEM_COUNT:  prdata = 32'(cfg_r.elem_count);
      REG_KEY_COUNT:   prdata = 32'(cfg_r.key_count);
      REG_FIRST_START: prdata = cfg_r.first_start;
      REG_FIRST_END:   prdata = cfg_r.first_end;
      default:         prdata = 32'd0;
    endcase
  end

  dkti_front #(.MAX_ELEMS(MAX_ELEMS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_kind         (in_kind),
    .in_elem_index   (in_elem_index),
    .in_start_value  (in_start_value),
    .in_delta_value  (in_delta_value),
    .in_key_addr     (in_key_addr),
    .in_key_byte     (in_key_byte),
    .in_frame_number (in_frame_number),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  dkti_back #(.MAX_ELEMS(MAX_ELEMS), .KEY_BYTES(KEY_BYTES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_value       (out_value),
    .out_value_index (out_value_index)
  );

endmodule

[bench/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dkti_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic [7:0]  vidx;
  } read_beat_t;

  // Tracks the keyframe track state and the reads still owed by the block
  class keyframe_track_model;
    logic [8:0]  elem_count;
    logic [15:0] key_count;
    logic [31:0] first_start;
    logic [31:0] first_end;
    logic signed [31:0] start_mem [256];
    logic signed [31:0] delta_mem [256];
    logic [7:0]  key_mem [65536];
    logic [31:0] span_start;
    logic [31:0] span_end;
    logic [15:0] keys_left;
    logic [15:0] rd_ptr;
    logic [16:0] frac;
    read_beat_t  pending_reads [$];
    int          errors;
    int          reads_checked;
    int          keys_walked;

    function void reset_state();
      elem_count = ELEM_COUNT_RST;
      key_count = 0;
      first_start = 0;
      first_end = 0;
      span_start = 0;
      span_end = 0;
      keys_left = 0;
      rd_ptr = 0;
      frac = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_ELEM_COUNT:  elem_count = v[8:0];
        REG_KEY_COUNT:   key_count = v[15:0];
        REG_FIRST_START: first_start = v;
        REG_FIRST_END:   first_end = v;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // Scale a difference byte by 2^(16+e), floor, saturate
    function logic signed [31:0] scaled_diff(logic signed [7:0] d, logic signed [7:0] e);
      int sh;
      int n;
      logic signed [7:0] q;
      sh = 16 + int'(e);
      if (d == 0) return 0;
      if (sh >= 0) begin
        if (sh > 32) return (d > 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return clamp32(longint'(d) <<< sh);
      end
      n = -sh;
      if (n >= 8) return (d < 0) ? -32'sd1 : 32'sd0;
      q = d >>> n;
      return 32'(q);
    endfunction

    function logic [7:0] pull_key_byte();
      logic [7:0] b;
      b = key_mem[rd_ptr];
      rd_ptr = rd_ptr + 16'd1;
      return b;
    endfunction

    function void walk_key();
      int n;
      logic signed [7:0] e;
      logic signed [7:0] d;
      logic [31:0] ef;
      n = (elem_count > 9'd256) ? 256 : int'(elem_count);
      e = pull_key_byte();
      for (int i = 0; i < n; i++) begin
        d = pull_key_byte();
        start_mem[i] = clamp32(longint'(start_mem[i]) + longint'(delta_mem[i]));
        delta_mem[i] = scaled_diff(d, e);
      end
      ef = 0;
      for (int i = 0; i < 4; i++) ef[8*i +: 8] = pull_key_byte();
      span_start = span_end;
      span_end = ef;
      keys_left = keys_left - 16'd1;
      keys_walked++;
    endfunction

    function void advance_to(logic [31:0] frame);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] q;
      while (frame > span_end && keys_left > 0) walk_key();
      if (frame > span_end || span_end <= span_start) begin
        frac = T_ONE;
      end else if (frame <= span_start) begin
        frac = 0;
      end else begin
        num = 64'(frame - span_start) << 16;
        den = 64'(span_end - span_start);
        q = num / den;
        frac = (q > 64'(T_ONE)) ? T_ONE : q[16:0];
      end
    endfunction

    // Apply one accepted input beat
    function void note_item(logic [2:0] kind, logic [7:0] idx, logic [31:0] sv,
                            logic [31:0] dv, logic [15:0] ka, logic [7:0] kb,
                            logic [31:0] fr);
      read_beat_t r;
      longint p;
      case (kind)
        KIND_LOAD: begin
          start_mem[idx] = sv;
          delta_mem[idx] = dv;
        end
        KIND_KEY: key_mem[ka] = kb;
        KIND_RESTART: begin
          span_start = first_start;
          span_end = first_end;
          keys_left = key_count;
          rd_ptr = 0;
          frac = 0;
        end
        KIND_ADVANCE: advance_to(fr);
        KIND_READ: begin
          p = longint'(delta_mem[idx]) * longint'({15'd0, frac});
          r.value = clamp32(longint'(start_mem[idx]) + (p >>> 16));
          r.vidx = idx;
          pending_reads.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result beat with the oldest owed read
    function void check_value(logic [31:0] value, logic [7:0] vidx);
      read_beat_t r;
      if (pending_reads.size() == 0) begin
        $error("unexpected result beat value=%h index=%0d", value, vidx);
        errors++;
        return;
      end
      r = pending_reads.pop_front();
      reads_checked++;
      if (value !== r.value) begin
        $error("value mismatch: expected %h actual %h", r.value, value);
        errors++;
      end
      if (vidx !== r.vidx) begin
        $error("value_index mismatch: expected %0d actual %0d", r.vidx, vidx);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [2:0]  in_kind = '0;
  logic [7:0]  in_elem_index = '0;
  logic [31:0] in_start_value = '0;
  logic [31:0] in_delta_value = '0;
  logic [15:0] in_key_addr = '0;
  logic [7:0]  in_key_byte = '0;
  logic [31:0] in_frame_number = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_value;
  logic [7:0]  out_value_index;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  keyframe_track_model track = new();
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int items_sent = 0;
  logic [31:0] key_ends [$];

  delta_keyframe_track_interpolator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_kind(in_kind),
    .in_elem_index(in_elem_index), .in_start_value(in_start_value),
    .in_delta_value(in_delta_value), .in_key_addr(in_key_addr),
    .in_key_byte(in_key_byte), .in_frame_number(in_frame_number),
    .out_empty(out_empty), .out_pop(out_pop), .out_value(out_value),
    .out_value_index(out_value_index),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // Sample both handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        track.note_item(in_kind, in_elem_index, in_start_value, in_delta_value,
                        in_key_addr, in_key_byte, in_frame_number);
      end
      if (out_pop && !out_empty) track.check_value(out_value, out_value_index);
    end
  end

  // Hold one input beat until accepted, idling first at random
  task automatic send(logic [2:0] kind, logic [7:0] idx, logic [31:0] sv,
                      logic [31:0] dv, logic [15:0] ka, logic [7:0] kb,
                      logic [31:0] fr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_kind <= kind;
    in_elem_index <= idx;
    in_start_value <= sv;
    in_delta_value <= dv;
    in_key_addr <= ka;
    in_key_byte <= kb;
    in_frame_number <= fr;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic send_simple(logic [2:0] kind, logic [7:0] idx, logic [31:0] fr);
    send(kind, idx, $urandom, $urandom, 16'($urandom), 8'($urandom), fr);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    track.set_reg(r, v);
  endtask

  // Drop the push, wait out every owed read and the longest walk
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    wait (track.pending_reads.size() == 0);
    repeat (2000) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] ec, logic [31:0] kc, logic [31:0] fs,
                           logic [31:0] fe);
    write_reg(REG_ELEM_COUNT, ec);
    write_reg(REG_KEY_COUNT, kc);
    write_reg(REG_FIRST_START, fs);
    write_reg(REG_FIRST_END, fe);
  endtask

  // Write the key records that the walk can reach; cap the end if more are counted
  task automatic write_keys(int nkeys, logic signed [7:0] exps [$]);
    int n;
    int addr;
    logic [31:0] ef;
    logic [7:0] e;
    n = (track.elem_count > 9'd256) ? 256 : int'(track.elem_count);
    addr = 0;
    ef = track.first_end;
    key_ends.delete();
    key_ends.push_back(track.first_start);
    key_ends.push_back(ef);
    for (int k = 0; k < nkeys; k++) begin
      e = (k < exps.size()) ? exps[k] : 8'($urandom_range(0, 40) - 28);
      if ($urandom_range(0, 9) == 0) e = $urandom;
      send(KIND_KEY, 0, 0, 0, 16'(addr), e, 0);
      addr++;
      for (int i = 0; i < n; i++) begin
        send(KIND_KEY, 0, 0, 0, 16'(addr), 8'($urandom), 0);
        addr++;
      end
      if (k == nkeys - 1 && int'(track.key_count) > nkeys) ef = 32'hFFFF_FFFF;
      else if ($urandom_range(0, 7) == 0) ef = $urandom;
      else ef = ef + $urandom_range(1, 300);
      key_ends.push_back(ef);
      for (int i = 0; i < 4; i++) begin
        send(KIND_KEY, 0, 0, 0, 16'(addr), ef[8*i +: 8], 0);
        addr++;
      end
    end
  endtask

  function automatic logic [31:0] pick_frame();
    logic [31:0] b;
    if ($urandom_range(0, 3) == 0) return $urandom;
    b = key_ends[$urandom_range(0, key_ends.size() - 1)];
    return b + 32'($urandom_range(0, 60)) - 32'd30;
  endfunction

  // Reads and loads stay on the loaded elements; stray key bytes land past the records
  task automatic random_items(int count, bit hold_off);
    int r;
    for (int i = 0; i < count; i++) begin
      if (hold_off && i == count / 2) begin
        @(negedge clk);
        in_push <= 1'b0;
        wait (track.pending_reads.size() == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 40) send_simple(KIND_READ, 8'($urandom_range(0, 15)), $urandom);
      else if (r < 65) send_simple(KIND_ADVANCE, 8'($urandom), pick_frame());
      else if (r < 75) send(KIND_LOAD, 8'($urandom_range(0, 15)), $urandom, $urandom,
                            0, 0, 0);
      else if (r < 82) send(KIND_KEY, 0, 0, 0, 16'($urandom_range(1024, 65535)),
                            8'($urandom), $urandom);
      else if (r < 90) send_simple(KIND_RESTART, 8'($urandom), $urandom);
      else if (r < 94) send_simple(3'($urandom_range(5, 7)), 8'($urandom), $urandom);
      else send(KIND_LOAD, 8'($urandom_range(0, 15)), 32'h8000_0000 ^ {31'd0, r[0]},
                32'h7FFF_FFFF ^ {32{r[1]}}, 0, 0, 0);
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
      1: begin send_idle_pct = 52; pop_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  pop_stall_pct = 52; end
      default: begin send_idle_pct = 31; pop_stall_pct = 31; end
    endcase
  endtask

  // Run limit
  initial begin
    #3_000_000;
    $display("timeout with %0d reads owed", track.pending_reads.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic signed [7:0] exps [$];
    track.reset_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the elements that reads and walks touch so none sees an unwritten entry
    for (int i = 0; i < 16; i++) send(KIND_LOAD, 8'(i), $urandom, $urandom, 0, 0, 0);

    // Directed: field extremes, rounding and span corner cases
    drain();
    configure(3, 3, 10, 20);
    exps = '{8'sd127, -8'sd128, -8'sd3};
    write_keys(3, exps);
    send(KIND_LOAD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    send(KIND_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send(KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0);
    send_simple(KIND_RESTART, 0, 0);
    send_simple(KIND_READ, 0, 0);
    send_simple(KIND_ADVANCE, 0, 32'd0);
    send_simple(KIND_READ, 1, 0);
    send_simple(KIND_ADVANCE, 0, 32'd15);
    send_simple(KIND_READ, 0, 0);
    send_simple(KIND_READ, 1, 0);
    send_simple(KIND_ADVANCE, 0, 32'd20);
    send_simple(KIND_READ, 8'hFF, 0);
    send_simple(KIND_ADVANCE, 0, 32'd25);
    send_simple(KIND_READ, 0, 0);
    send_simple(KIND_READ, 2, 0);
    send_simple(3'd7, 8'hFF, 32'hFFFF_FFFF);
    send_simple(KIND_ADVANCE, 0, 32'hFFFF_FFFF);
    send_simple(KIND_READ, 1, 0);
    send_simple(KIND_READ, 8'hFF, 0);

    // Random phases over a spread of settings
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      set_idling(ph);
      case (ph)
        0: configure(0, 2, 32'd0, 32'd0);
        1: configure(1, 5, 32'd1000, 32'd1100);
        2: configure(511, 0, 32'd5, 32'd5);
        3: configure(4, 65535, 32'hFFFF_FFFF, 32'd0);
        4: configure(2, 0, 32'd50, 32'd90);
        5: configure(16, 2, 32'h7FFF_0000, 32'h7FFF_0040);
        default: configure($urandom_range(1, 6), $urandom_range(1, 4), 32'd300, 32'd400);
      endcase
      exps.delete();
      write_keys((track.key_count > 4) ? 4 : int'(track.key_count), exps);
      send_simple(KIND_RESTART, 0, 0);
      random_items(50, ph == 1);
    end
    drain();
    set_idling(0);

    $display("sent %0d input beats, checked %0d read results", items_sent,
             track.reads_checked);
    $display("walked %0d keys over seven settings and four idling mixes",
             track.keys_walked);
    if (track.errors == 0 && track.pending_reads.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
